@@ sv/npsf_pkg.sv @@
// Package for the nearest polyline segment finder.
// Holds widths, function codes and the status structs of the sum and divider units.
// No dependencies.
`default_nettype none

package npsf_pkg;

    localparam int POS_BITS    = 24;
    localparam int COORD_BITS  = 24;
    localparam int MAX_POINTS  = 256;
    localparam int CNT_BITS    = $clog2(MAX_POINTS + 1);
    localparam int MAG_BITS    = COORD_BITS;
    localparam int DIFF_BITS   = COORD_BITS + 1;
    localparam int LEN_BITS    = 2 * MAG_BITS + 2;
    localparam int DOT_BITS    = LEN_BITS + 1;
    localparam int DIST_BITS   = 52;
    localparam int IDX_BITS    = 8;
    localparam int SQ_CNT_BITS = $clog2(MAG_BITS + 1);
    localparam int MD_CNT_BITS = $clog2(LEN_BITS + 1);

    localparam logic FUNC_QUERY = 1'b0;
    localparam logic FUNC_POINT = 1'b1;

    localparam logic [DIST_BITS-1:0] DIST_ONES = '1;

    typedef logic signed [COORD_BITS-1:0] coord_t;

    typedef struct packed {
        coord_t x;
        coord_t y;
        coord_t z;
    } vec_t;

    typedef struct packed {
        logic                       done;
        logic [LEN_BITS-1:0]        len2;
        logic [LEN_BITS-1:0]        ap2;
        logic [LEN_BITS-1:0]        bp2;
        logic signed [DOT_BITS-1:0] dot;
    } sq_res_t;

    typedef struct packed {
        logic                done;
        logic [LEN_BITS-1:0] quot;
    } md_res_t;

endpackage

`default_nettype wire

@@ sv/npsf_if.sv @@
// Handshake channels of the nearest polyline segment finder.
// Point words in, result words out; depends on npsf_pkg.
`default_nettype none

interface npsf_point_if import npsf_pkg::*; ();
    logic                       valid;
    logic                       ready;
    logic                       func;
    logic signed [POS_BITS-1:0] pos_x;
    logic signed [POS_BITS-1:0] pos_y;
    logic signed [POS_BITS-1:0] pos_z;
    logic                       last_point;

    modport source (output valid, func, pos_x, pos_y, pos_z, last_point, input ready);
    modport sink (input valid, func, pos_x, pos_y, pos_z, last_point, output ready);
endinterface

interface npsf_result_if import npsf_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [IDX_BITS-1:0]  start_index;
    logic [DIST_BITS-1:0] best_dist_sq;
    logic                 overflow;

    modport source (output valid, start_index, best_dist_sq, overflow, input ready);
    modport sink (input valid, start_index, best_dist_sq, overflow, output ready);
endinterface

`default_nettype wire

@@ sv/npsf_sqsum.sv @@
// Bit-serial sums of products for one segment: |AB|^2, |AP|^2, |BP|^2 and AP.AB.
// Magnitudes shift out MSB first, one bit per cycle; depends on npsf_pkg.
`default_nettype none

module npsf_sqsum import npsf_pkg::*; (
    input  logic    clk,
    input  logic    rst_n,
    input  logic    start,
    input  vec_t    pa,
    input  vec_t    pb,
    input  vec_t    pp,
    output sq_res_t res
);

    logic                          busy_reg, busy_next;
    logic                          done_reg, done_next;
    logic [SQ_CNT_BITS-1:0]        cnt_reg, cnt_next;
    logic [2:0][MAG_BITS-1:0]      umag_reg, umag_next;
    logic [2:0][MAG_BITS-1:0]      vmag_reg, vmag_next;
    logic [2:0][MAG_BITS-1:0]      wmag_reg, wmag_next;
    logic [2:0][MAG_BITS-1:0]      ush_reg, ush_next;
    logic [2:0][MAG_BITS-1:0]      vsh_reg, vsh_next;
    logic [2:0][MAG_BITS-1:0]      wsh_reg, wsh_next;
    logic [2:0]                    flip_reg, flip_next;
    logic [LEN_BITS-1:0]           len_reg, len_next;
    logic [LEN_BITS-1:0]           ap_reg, ap_next;
    logic [LEN_BITS-1:0]           bp_reg, bp_next;
    logic signed [DOT_BITS-1:0]    dot_reg, dot_next;

    coord_t [2:0]                  ca, cb, cp;
    logic signed [DIFF_BITS-1:0]   du [3];
    logic signed [DIFF_BITS-1:0]   dv [3];
    logic signed [DIFF_BITS-1:0]   dw [3];
    logic [LEN_BITS-1:0]           len_add, ap_add, bp_add;
    logic signed [DOT_BITS-1:0]    dot_add;
    logic signed [DOT_BITS-1:0]    vext;

    always_comb
    begin
        ca = {pa.x, pa.y, pa.z};
        cb = {pb.x, pb.y, pb.z};
        cp = {pp.x, pp.y, pp.z};
        for (int i = 0; i < 3; i++)
        begin
            du[i] = DIFF_BITS'(cp[i]) - DIFF_BITS'(ca[i]);
            dv[i] = DIFF_BITS'(cb[i]) - DIFF_BITS'(ca[i]);
            dw[i] = DIFF_BITS'(cp[i]) - DIFF_BITS'(cb[i]);
        end

        len_add = '0;
        ap_add  = '0;
        bp_add  = '0;
        dot_add = '0;
        vext    = '0;
        for (int i = 0; i < 3; i++)
        begin
            if (vsh_reg[i][MAG_BITS-1])
            begin
                len_add = len_add + LEN_BITS'(vmag_reg[i]);
            end
            if (ush_reg[i][MAG_BITS-1])
            begin
                ap_add = ap_add + LEN_BITS'(umag_reg[i]);
                vext   = signed'(DOT_BITS'(vmag_reg[i]));
                if (flip_reg[i])
                begin
                    dot_add = dot_add - vext;
                end
                else
                begin
                    dot_add = dot_add + vext;
                end
            end
            if (wsh_reg[i][MAG_BITS-1])
            begin
                bp_add = bp_add + LEN_BITS'(wmag_reg[i]);
            end
        end

        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        umag_next = umag_reg;
        vmag_next = vmag_reg;
        wmag_next = wmag_reg;
        ush_next  = ush_reg;
        vsh_next  = vsh_reg;
        wsh_next  = wsh_reg;
        flip_next = flip_reg;
        len_next  = len_reg;
        ap_next   = ap_reg;
        bp_next   = bp_reg;
        dot_next  = dot_reg;

        if (start)
        begin
            for (int i = 0; i < 3; i++)
            begin
                umag_next[i] = du[i][DIFF_BITS-1] ? MAG_BITS'(-du[i]) : MAG_BITS'(du[i]);
                vmag_next[i] = dv[i][DIFF_BITS-1] ? MAG_BITS'(-dv[i]) : MAG_BITS'(dv[i]);
                wmag_next[i] = dw[i][DIFF_BITS-1] ? MAG_BITS'(-dw[i]) : MAG_BITS'(dw[i]);
                flip_next[i] = du[i][DIFF_BITS-1] ^ dv[i][DIFF_BITS-1];
            end
            ush_next  = umag_next;
            vsh_next  = vmag_next;
            wsh_next  = wmag_next;
            len_next  = '0;
            ap_next   = '0;
            bp_next   = '0;
            dot_next  = '0;
            cnt_next  = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            len_next = {len_reg[LEN_BITS-2:0], 1'b0} + len_add;
            ap_next  = {ap_reg[LEN_BITS-2:0], 1'b0} + ap_add;
            bp_next  = {bp_reg[LEN_BITS-2:0], 1'b0} + bp_add;
            dot_next = {dot_reg[DOT_BITS-2:0], 1'b0} + dot_add;
            for (int i = 0; i < 3; i++)
            begin
                ush_next[i] = {ush_reg[i][MAG_BITS-2:0], 1'b0};
                vsh_next[i] = {vsh_reg[i][MAG_BITS-2:0], 1'b0};
                wsh_next[i] = {wsh_reg[i][MAG_BITS-2:0], 1'b0};
            end
            cnt_next = cnt_reg + SQ_CNT_BITS'(1);
            if (cnt_reg == SQ_CNT_BITS'(MAG_BITS - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        umag_reg <= umag_next;
        vmag_reg <= vmag_next;
        wmag_reg <= wmag_next;
        ush_reg  <= ush_next;
        vsh_reg  <= vsh_next;
        wsh_reg  <= wsh_next;
        flip_reg <= flip_next;
        len_reg  <= len_next;
        ap_reg   <= ap_next;
        bp_reg   <= bp_next;
        dot_reg  <= dot_next;
    end

    assign res.done = done_reg;
    assign res.len2 = len_reg;
    assign res.ap2  = ap_reg;
    assign res.bp2  = bp_reg;
    assign res.dot  = dot_reg;

endmodule

`default_nettype wire

@@ sv/npsf_muldiv.sv @@
// Bit-serial squarer followed by a restoring divider: floor(dot^2 / len2).
// Expects 0 < dot < len2, so the quotient fits in LEN_BITS; depends on npsf_pkg.
`default_nettype none

module npsf_muldiv import npsf_pkg::*; (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  logic [LEN_BITS-1:0] dot,
    input  logic [LEN_BITS-1:0] len2,
    output md_res_t             res
);

    localparam logic [1:0] PH_IDLE = 2'd0;
    localparam logic [1:0] PH_MUL  = 2'd1;
    localparam logic [1:0] PH_DIV  = 2'd2;

    logic [1:0]             phase_reg, phase_next;
    logic                   done_reg, done_next;
    logic [MD_CNT_BITS-1:0] cnt_reg, cnt_next;
    logic [LEN_BITS-1:0]    mcand_reg, mcand_next;
    logic [LEN_BITS-1:0]    mplier_reg, mplier_next;
    logic [LEN_BITS-1:0]    div_reg, div_next;
    logic [LEN_BITS-1:0]    hi_reg, hi_next;
    logic [LEN_BITS-1:0]    lo_reg, lo_next;

    logic [LEN_BITS:0]      psum;
    logic [LEN_BITS:0]      trial;
    logic                   fits;

    always_comb
    begin
        psum  = {1'b0, hi_reg} + (mplier_reg[0] ? {1'b0, mcand_reg} : '0);
        trial = {hi_reg, lo_reg[LEN_BITS-1]};
        fits  = trial >= {1'b0, div_reg};

        phase_next  = phase_reg;
        done_next   = 1'b0;
        cnt_next    = cnt_reg;
        mcand_next  = mcand_reg;
        mplier_next = mplier_reg;
        div_next    = div_reg;
        hi_next     = hi_reg;
        lo_next     = lo_reg;

        case (phase_reg)
            PH_IDLE:
            begin
                if (start)
                begin
                    mcand_next  = dot;
                    mplier_next = dot;
                    div_next    = len2;
                    hi_next     = '0;
                    lo_next     = '0;
                    cnt_next    = '0;
                    phase_next  = PH_MUL;
                end
            end
            PH_MUL:
            begin
                hi_next     = psum[LEN_BITS:1];
                lo_next     = {psum[0], lo_reg[LEN_BITS-1:1]};
                mplier_next = {1'b0, mplier_reg[LEN_BITS-1:1]};
                cnt_next    = cnt_reg + MD_CNT_BITS'(1);
                if (cnt_reg == MD_CNT_BITS'(LEN_BITS - 1))
                begin
                    cnt_next   = '0;
                    phase_next = PH_DIV;
                end
            end
            PH_DIV:
            begin
                hi_next  = fits ? LEN_BITS'(trial - {1'b0, div_reg}) : LEN_BITS'(trial);
                lo_next  = {lo_reg[LEN_BITS-2:0], fits};
                cnt_next = cnt_reg + MD_CNT_BITS'(1);
                if (cnt_reg == MD_CNT_BITS'(LEN_BITS - 1))
                begin
                    phase_next = PH_IDLE;
                    done_next  = 1'b1;
                end
            end
            default:
            begin
                phase_next = PH_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
            done_reg  <= 1'b0;
            cnt_reg   <= '0;
        end
        else
        begin
            phase_reg <= phase_next;
            done_reg  <= done_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mcand_reg  <= mcand_next;
        mplier_reg <= mplier_next;
        div_reg    <= div_next;
        hi_reg     <= hi_next;
        lo_reg     <= lo_next;
    end

    assign res.done = done_reg;
    assign res.quot = lo_reg;

    // The partial remainder must stay below the divisor for the quotient to fit.
    a_rem_below_div: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_DIV |-> hi_reg < div_reg)
        else $error("remainder not below divisor");

endmodule

`default_nettype wire

@@ sv/nearest_polyline_segment_finder_top.sv @@
// Nearest polyline segment finder: top level with the route state and control.
// Uses npsf_pkg, npsf_if, npsf_sqsum and npsf_muldiv.
//
// A query word (func = 0), a route point that opens a route, and a route point
// that comes after MAX_POINTS points are taken in the idle state. A point that
// closes a segment first waits for the bit-serial sums of products; when the
// nearest point is an endpoint it goes straight to the update, otherwise the
// dot product is squared and then divided by the squared length, one bit per
// cycle each. A point marked last then goes to the final state, which hands the
// result word to the output register and waits there while a previous result
// word has not been taken.
`default_nettype none

module nearest_polyline_segment_finder_top import npsf_pkg::*; (
    input  logic          clk,
    input  logic          rst_n,
    npsf_point_if.sink    point,
    npsf_result_if.source result
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_SQ   = 3'd1;
    localparam logic [2:0] S_DIV  = 3'd2;
    localparam logic [2:0] S_UPD  = 3'd3;
    localparam logic [2:0] S_FIN  = 3'd4;

    logic [2:0]           state_reg, state_next;
    vec_t                 query_reg, query_next;
    vec_t                 prev_reg, prev_next;
    vec_t                 cur_reg, cur_next;
    logic                 last_reg, last_next;
    logic [CNT_BITS-1:0]  cnt_reg, cnt_next;
    logic [DIST_BITS-1:0] best_reg, best_next;
    logic [CNT_BITS-1:0]  seg_reg, seg_next;
    logic                 ovf_reg, ovf_next;
    logic [DIST_BITS-1:0] dist_reg, dist_next;
    logic                 out_valid_reg, out_valid_next;
    logic [IDX_BITS-1:0]  out_idx_reg, out_idx_next;
    logic [DIST_BITS-1:0] out_dist_reg, out_dist_next;
    logic                 out_ovf_reg, out_ovf_next;

    logic                 accept;
    vec_t                 in_pos;
    logic                 sq_start;
    logic                 md_start;
    sq_res_t              sq_res;
    md_res_t              md_res;
    logic                 dot_nonpos;
    logic                 dot_past_b;
    logic                 two_points;

    npsf_sqsum u_sqsum (
        .clk   (clk),
        .rst_n (rst_n),
        .start (sq_start),
        .pa    (prev_reg),
        .pb    (cur_next),
        .pp    (query_reg),
        .res   (sq_res)
    );

    npsf_muldiv u_muldiv (
        .clk   (clk),
        .rst_n (rst_n),
        .start (md_start),
        .dot   (sq_res.dot[LEN_BITS-1:0]),
        .len2  (sq_res.len2),
        .res   (md_res)
    );

    assign point.ready = (state_reg == S_IDLE);
    assign accept      = point.valid && point.ready;

    assign in_pos.x = coord_t'(point.pos_x[COORD_BITS-1:0]);
    assign in_pos.y = coord_t'(point.pos_y[COORD_BITS-1:0]);
    assign in_pos.z = coord_t'(point.pos_z[COORD_BITS-1:0]);

    assign dot_nonpos = sq_res.dot[DOT_BITS-1] || (sq_res.dot == '0);
    assign dot_past_b = sq_res.dot[LEN_BITS-1:0] >= sq_res.len2;
    assign two_points = cnt_reg >= CNT_BITS'(2);

    always_comb
    begin
        state_next     = state_reg;
        query_next     = query_reg;
        prev_next      = prev_reg;
        cur_next       = cur_reg;
        last_next      = last_reg;
        cnt_next       = cnt_reg;
        best_next      = best_reg;
        seg_next       = seg_reg;
        ovf_next       = ovf_reg;
        dist_next      = dist_reg;
        out_valid_next = out_valid_reg && !result.ready;
        out_idx_next   = out_idx_reg;
        out_dist_next  = out_dist_reg;
        out_ovf_next   = out_ovf_reg;
        sq_start       = 1'b0;
        md_start       = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    if (point.func == FUNC_QUERY)
                    begin
                        query_next = in_pos;
                        cnt_next   = '0;
                        best_next  = DIST_ONES;
                        seg_next   = '0;
                        ovf_next   = 1'b0;
                    end
                    else
                    begin
                        cur_next  = in_pos;
                        last_next = point.last_point;
                        if (cnt_reg >= CNT_BITS'(MAX_POINTS))
                        begin
                            ovf_next   = 1'b1;
                            state_next = point.last_point ? S_FIN : S_IDLE;
                        end
                        else if (cnt_reg != '0)
                        begin
                            sq_start   = 1'b1;
                            state_next = S_SQ;
                        end
                        else
                        begin
                            prev_next  = in_pos;
                            cnt_next   = CNT_BITS'(1);
                            state_next = point.last_point ? S_FIN : S_IDLE;
                        end
                    end
                end
            end
            S_SQ:
            begin
                if (sq_res.done)
                begin
                    if ((sq_res.len2 == '0) || dot_nonpos)
                    begin
                        dist_next  = DIST_BITS'(sq_res.ap2);
                        state_next = S_UPD;
                    end
                    else if (dot_past_b)
                    begin
                        dist_next  = DIST_BITS'(sq_res.bp2);
                        state_next = S_UPD;
                    end
                    else
                    begin
                        dist_next  = DIST_BITS'(sq_res.ap2);
                        md_start   = 1'b1;
                        state_next = S_DIV;
                    end
                end
            end
            S_DIV:
            begin
                if (md_res.done)
                begin
                    dist_next  = dist_reg - DIST_BITS'(md_res.quot);
                    state_next = S_UPD;
                end
            end
            S_UPD:
            begin
                if (dist_reg < best_reg)
                begin
                    best_next = dist_reg;
                    seg_next  = cnt_reg - CNT_BITS'(1);
                end
                prev_next  = cur_reg;
                cnt_next   = cnt_reg + CNT_BITS'(1);
                state_next = last_reg ? S_FIN : S_IDLE;
            end
            S_FIN:
            begin
                if (!out_valid_reg || result.ready)
                begin
                    out_valid_next = 1'b1;
                    out_idx_next   = two_points ? IDX_BITS'(seg_reg + CNT_BITS'(1)) : '0;
                    out_dist_next  = two_points ? best_reg : DIST_ONES;
                    out_ovf_next   = ovf_reg;
                    cnt_next       = '0;
                    best_next      = DIST_ONES;
                    seg_next       = '0;
                    ovf_next       = 1'b0;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            query_reg     <= '0;
            prev_reg      <= '0;
            cnt_reg       <= '0;
            best_reg      <= DIST_ONES;
            seg_reg       <= '0;
            ovf_reg       <= 1'b0;
            last_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            query_reg     <= query_next;
            prev_reg      <= prev_next;
            cnt_reg       <= cnt_next;
            best_reg      <= best_next;
            seg_reg       <= seg_next;
            ovf_reg       <= ovf_next;
            last_reg      <= last_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg      <= cur_next;
        dist_reg     <= dist_next;
        out_idx_reg  <= out_idx_next;
        out_dist_reg <= out_dist_next;
        out_ovf_reg  <= out_ovf_next;
    end

    assign result.valid        = out_valid_reg;
    assign result.start_index  = out_idx_reg;
    assign result.best_dist_sq = out_dist_reg;
    assign result.overflow     = out_ovf_reg;

    a_cnt_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CNT_BITS'(MAX_POINTS))
        else $error("point count beyond the route limit");

    a_sq_done_in_sq: assert property (@(posedge clk) disable iff (!rst_n)
        sq_res.done |-> state_reg == S_SQ)
        else $error("sum unit finished outside its wait state");

    a_md_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
        md_res.done |-> state_reg == S_DIV)
        else $error("divider finished outside its wait state");

    a_no_segment_no_best: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg < CNT_BITS'(2) |-> best_reg == DIST_ONES)
        else $error("best distance set without a segment");

endmodule

`default_nettype wire

@@ tb/npsf_checker.sv @@
// Checker for the nearest polyline segment finder: watches both channels,
// predicts each result word from the accepted point words and compares them.
// Depends on npsf_pkg and the channel interfaces in npsf_if.
`default_nettype none

module npsf_checker import npsf_pkg::*; (
    input  logic          clk,
    input  logic          rst_n,
    npsf_point_if         pt,
    npsf_result_if        res,
    output int            errors,
    output int            pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [IDX_BITS-1:0]  index;
        logic [DIST_BITS-1:0] dist_val;
        logic                 ovf;
    } route_result_t;

    route_result_t        nearest_expected[$];
    route_result_t        want;
    vec_t                 query_pt;
    vec_t                 prev_pt;
    vec_t                 cur_pt;
    int unsigned          pt_count;
    logic [DIST_BITS-1:0] best_dist;
    logic [DIST_BITS-1:0] seg_dist;
    int unsigned          best_seg;
    logic                 ovf_seen;

    assign pending = nearest_expected.size();

    function automatic logic [63:0] dist_sq(vec_t a, vec_t b);
        longint dx;
        longint dy;
        longint dz;
        dx = longint'(b.x) - longint'(a.x);
        dy = longint'(b.y) - longint'(a.y);
        dz = longint'(b.z) - longint'(a.z);
        return 64'(dx * dx + dy * dy + dz * dz);
    endfunction

    // Squared distance from p to the closest point of segment a-b.
    function automatic logic [DIST_BITS-1:0] segment_dist_sq(vec_t a, vec_t b, vec_t p);
        longint       dot;
        logic [63:0]  len2;
        logic [63:0]  ap2;
        logic [63:0]  bp2;
        logic [127:0] dot_sq;
        logic [127:0] quot;
        len2 = dist_sq(a, b);
        ap2  = dist_sq(a, p);
        bp2  = dist_sq(b, p);
        dot  = (longint'(p.x) - longint'(a.x)) * (longint'(b.x) - longint'(a.x))
             + (longint'(p.y) - longint'(a.y)) * (longint'(b.y) - longint'(a.y))
             + (longint'(p.z) - longint'(a.z)) * (longint'(b.z) - longint'(a.z));
        if (len2 == 0 || dot <= 0)
        begin
            return ap2[DIST_BITS-1:0];
        end
        if (dot >= longint'(len2))
        begin
            return bp2[DIST_BITS-1:0];
        end
        dot_sq = {64'd0, dot} * {64'd0, dot};
        quot   = dot_sq / {64'd0, len2};
        ap2    = ap2 - quot[63:0];
        return ap2[DIST_BITS-1:0];
    endfunction

    task clear_route();
        pt_count  = 0;
        best_dist = DIST_ONES;
        best_seg  = 0;
        ovf_seen  = 1'b0;
    endtask

    task report(input string msg);
        $display("%0t mismatch: %s", $realtime, msg);
        errors = errors + 1;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            query_pt = '0;
            prev_pt  = '0;
            errors   = 0;
            nearest_expected.delete();
            clear_route();
        end
        else
        begin
            if (pt.valid && pt.ready)
            begin
                cur_pt.x = pt.pos_x[COORD_BITS-1:0];
                cur_pt.y = pt.pos_y[COORD_BITS-1:0];
                cur_pt.z = pt.pos_z[COORD_BITS-1:0];
                if (pt.func == FUNC_QUERY)
                begin
                    query_pt = cur_pt;
                    clear_route();
                end
                else
                begin
                    if (pt_count >= MAX_POINTS)
                    begin
                        ovf_seen = 1'b1;
                    end
                    else
                    begin
                        if (pt_count >= 1)
                        begin
                            seg_dist = segment_dist_sq(prev_pt, cur_pt, query_pt);
                            if (seg_dist < best_dist)
                            begin
                                best_dist = seg_dist;
                                best_seg  = pt_count - 1;
                            end
                        end
                        prev_pt  = cur_pt;
                        pt_count = pt_count + 1;
                    end
                    if (pt.last_point)
                    begin
                        want.index    = (pt_count >= 2) ? IDX_BITS'(best_seg + 1) : '0;
                        want.dist_val = (pt_count >= 2) ? best_dist : DIST_ONES;
                        want.ovf      = ovf_seen;
                        nearest_expected.push_back(want);
                        clear_route();
                    end
                end
            end
            if (res.valid && res.ready)
            begin
                if (nearest_expected.size() == 0)
                begin
                    report($sformatf("result word with none expected: index %0d dist %0d",
                                     res.start_index, res.best_dist_sq));
                end
                else
                begin
                    want = nearest_expected.pop_front();
                    if (res.start_index !== want.index)
                    begin
                        report($sformatf("start_index got %0d expected %0d",
                                         res.start_index, want.index));
                    end
                    if (res.best_dist_sq !== want.dist_val)
                    begin
                        report($sformatf("best_dist_sq got %0d expected %0d",
                                         res.best_dist_sq, want.dist_val));
                    end
                    if (res.overflow !== want.ovf)
                    begin
                        report($sformatf("overflow got %0b expected %0b",
                                         res.overflow, want.ovf));
                    end
                end
            end
        end
    end

endmodule

`default_nettype wire

@@ tb/tb.sv @@
// Testbench top for the nearest polyline segment finder: clock, reset, point
// word stimulus, result-side back pressure, watchdog and the final verdict.
// Depends on npsf_pkg, npsf_if, the block itself and npsf_checker.
`default_nettype none

module tb import npsf_pkg::*; ();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int     HOLD_CYCLES    = 800;
    localparam int     SETTLE_CYCLES  = 200;
    localparam int     WATCHDOG_LIMIT = 4000;
    localparam int     RANDOM_WORDS   = 300;
    localparam int     OVF_ROUTE_LEN  = MAX_POINTS + 2;
    localparam coord_t COORD_MAX      = coord_t'((1 << (COORD_BITS - 1)) - 1);
    localparam coord_t COORD_MIN      = ~COORD_MAX;

    logic   clk;
    logic   rst_n;
    int     errors;
    int     pending;
    int     words_sent;
    int     stall_cycles;
    bit     quiet;
    bit     hold_req;
    coord_t qx;
    coord_t qy;
    coord_t qz;

    npsf_point_if  pt();
    npsf_result_if res();

    nearest_polyline_segment_finder_top u_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .point  (pt),
        .result (res)
    );

    npsf_checker u_checker (
        .clk     (clk),
        .rst_n   (rst_n),
        .pt      (pt),
        .res     (res),
        .errors  (errors),
        .pending (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    task automatic send_word(input logic f, input coord_t x, input coord_t y,
                             input coord_t z, input logic last);
        int gap;
        gap = 0;
        if (!quiet && $urandom_range(99) < 6)
        begin
            gap = $urandom_range(1, 4);
        end
        if (gap > 0)
        begin
            pt.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        pt.valid      <= 1'b1;
        pt.func       <= f;
        pt.pos_x      <= x;
        pt.pos_y      <= y;
        pt.pos_z      <= z;
        pt.last_point <= last;
        @(posedge clk);
        while (!pt.ready) @(posedge clk);
        words_sent = words_sent + 1;
    endtask

    task automatic send_query(input coord_t x, input coord_t y, input coord_t z,
                              input logic last);
        qx = x;
        qy = y;
        qz = z;
        send_word(FUNC_QUERY, x, y, z, last);
    endtask

    // Spread 0 draws from the whole range, COORD_BITS or more picks extremes,
    // anything else stays within 2**spread of the center.
    function automatic coord_t pick_coord(coord_t center, int spread);
        logic [31:0] r;
        int          off;
        r = $urandom;
        if (spread == 0)
        begin
            return coord_t'(r[COORD_BITS-1:0]);
        end
        if (spread >= COORD_BITS)
        begin
            case (r[1:0])
                2'd0:    return COORD_MIN;
                2'd1:    return COORD_MAX;
                2'd2:    return '0;
                default: return '1;
            endcase
        end
        off = int'($urandom_range(0, 1 << (spread + 1))) - (1 << spread);
        return coord_t'(center + off);
    endfunction

    function automatic int pick_spread();
        int r;
        r = $urandom_range(9);
        if (r < 2)
        begin
            return 0;
        end
        if (r == 2)
        begin
            return COORD_BITS;
        end
        return $urandom_range(2, 16);
    endfunction

    task automatic drain();
        pt.valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic random_route();
        int len;
        int spread;
        int i;
        len    = $urandom_range(1, 6);
        spread = pick_spread();
        if ($urandom_range(9) == 0)
        begin
            len = $urandom_range(7, 20);
        end
        for (i = 0; i < len; i++)
        begin
            if (i < len - 1 && $urandom_range(19) == 0)
            begin
                send_query(pick_coord(qx, spread), pick_coord(qy, spread),
                           pick_coord(qz, spread), 1'($urandom_range(1)));
            end
            send_word(FUNC_POINT, pick_coord(qx, spread), pick_coord(qy, spread),
                      pick_coord(qz, spread), i == len - 1);
        end
    endtask

    // The receiver stops for a long stretch while short routes keep coming,
    // so result words back up into the block and its input stalls.
    task automatic fill_while_held();
        int r;
        hold_req = 1'b1;
        for (r = 0; r < 5; r++)
        begin
            send_word(FUNC_POINT, pick_coord(qx, 10), pick_coord(qy, 10),
                      pick_coord(qz, 10), 1'b0);
            send_word(FUNC_POINT, pick_coord(qx, 10), pick_coord(qy, 10),
                      pick_coord(qz, 10), 1'b1);
        end
        drain();
    endtask

    initial
    begin
        res.ready <= 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (hold_req)
            begin
                hold_req = 1'b0;
                res.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            else
            begin
                res.ready <= quiet || ($urandom_range(99) >= 6);
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            stall_cycles <= 0;
        end
        else if ((pt.valid && pt.ready) || (res.valid && res.ready))
        begin
            stall_cycles <= 0;
        end
        else if (stall_cycles >= WATCHDOG_LIMIT)
        begin
            $display("RESULT: ERROR");
            $finish;
        end
        else
        begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    initial
    begin
        int start;
        int i;
        bit pressed;
        words_sent    = 0;
        quiet         = 1'b0;
        pressed       = 1'b0;
        qx            = '0;
        qy            = '0;
        qz            = '0;
        rst_n         <= 1'b0;
        pt.valid      <= 1'b0;
        pt.func       <= FUNC_QUERY;
        pt.pos_x      <= '0;
        pt.pos_y      <= '0;
        pt.pos_z      <= '0;
        pt.last_point <= 1'b0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // A lone point before any query ends a route with no segment.
        send_word(FUNC_POINT, 1, 2, 3, 1'b1);
        send_word(FUNC_POINT, COORD_MIN, COORD_MIN, COORD_MIN, 1'b0);
        send_word(FUNC_POINT, COORD_MAX, COORD_MAX, COORD_MAX, 1'b1);
        // Degenerate segments tie, then a segment passes through the query.
        send_query(0, 0, 0, 1'b1);
        send_word(FUNC_POINT, 16, 0, 0, 1'b0);
        send_word(FUNC_POINT, 16, 0, 0, 1'b0);
        send_word(FUNC_POINT, 16, 0, 0, 1'b0);
        send_word(FUNC_POINT, -16, 0, 0, 1'b1);
        // Projection falls before the start, then beyond the end.
        send_word(FUNC_POINT, 32, 0, 0, 1'b0);
        send_word(FUNC_POINT, 64, 0, 0, 1'b0);
        send_word(FUNC_POINT, 16, 0, 0, 1'b1);
        send_query(5, 7, -3, 1'b0);
        send_word(FUNC_POINT, 0, 0, 0, 1'b0);
        send_word(FUNC_POINT, 100, 3, -50, 1'b1);
        send_query(COORD_MAX, COORD_MIN, COORD_MAX, 1'b0);
        send_word(FUNC_POINT, COORD_MIN, COORD_MAX, COORD_MIN, 1'b0);
        send_word(FUNC_POINT, COORD_MAX, COORD_MAX, COORD_MIN, 1'b0);
        send_word(FUNC_POINT, 0, 0, 0, 1'b1);
        // A query in the middle of a route starts it over.
        send_query(0, 0, 0, 1'b0);
        send_word(FUNC_POINT, 48, 0, 0, 1'b0);
        send_word(FUNC_POINT, 48, 48, 0, 1'b0);
        send_query(0, 0, 0, 1'b0);
        send_word(FUNC_POINT, 7, -9, 11, 1'b1);
        drain();

        fill_while_held();

        // A route longer than MAX_POINTS points sets the overflow flag.
        send_query(pick_coord(0, 0), pick_coord(0, 0), pick_coord(0, 0), 1'b0);
        for (i = 0; i < OVF_ROUTE_LEN; i++)
        begin
            send_word(FUNC_POINT, pick_coord(qx, 14), pick_coord(qy, 14),
                      pick_coord(qz, 14), i == OVF_ROUTE_LEN - 1);
        end
        drain();

        start = words_sent;
        while (words_sent - start < RANDOM_WORDS)
        begin
            quiet = (words_sent - start >= 80) && (words_sent - start < 160);
            if (!pressed && words_sent - start >= 200)
            begin
                fill_while_held();
                pressed = 1'b1;
            end
            if ($urandom_range(7) == 0)
            begin
                send_query(pick_coord(qx, 0), pick_coord(qy, 0), pick_coord(qz, 0),
                           1'($urandom_range(1)));
            end
            random_route();
        end
        quiet = 1'b0;
        drain();

        if (errors == 0 && pending == 0)
        begin
            $display("RESULT: OK");
        end
        else
        begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

`default_nettype wire
